// ===== hw/rtl/cal_pkg.sv =====
package cal_pkg;

    // Number of element cells in the chain.
    localparam int CAPACITY = 64;
    // Bits in one stored element.
    localparam int ELEM_W = 16;
    // Bits in a count or cursor value, which runs from zero up to CAPACITY.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_APPEND   = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_TO_START = 3'd3,
        OP_TO_END   = 3'd4,
        OP_PREV     = 3'd5,
        OP_NEXT     = 3'd6,
        OP_SET_POS  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_NO_ELEM = 2'd2,
        ERR_BAD_POS = 2'd3
    } err_t;

    // Command broadcast to every cell of the chain in the cycle a word is taken.
    typedef struct packed {
        logic              ins;
        logic              app;
        logic              rem;
        logic [CNT_W-1:0]  cursor;
        logic [CNT_W-1:0]  count;
        logic [ELEM_W-1:0] item;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/cursor_array_list_unit.sv =====
// Ordered list with a cursor, held in a chain of element cells.
// The input channel (in_valid/in_ready) carries one word per operation:
// operation, clear_request, item_value and target_position. The output
// channel (out_valid/out_ready) returns one word per operation: the removed
// element, the length and cursor after the operation, and an error code.
// Every operation takes one cycle: all cells shift towards or away from the
// cursor together, so a result word is registered one cycle after the input
// word is taken, and a new word may be taken every cycle.
// The output register parts the two sides: a new input word is taken
// whenever the output register is empty or its word is taken in the same
// cycle. When the receiver stalls, the result word holds and in_ready drops.
// Reset empties the list and puts the cursor at zero; the element cells are
// not cleared, since only entries below the length are ever read.
// A failed check (full list, no element at the cursor, position beyond the
// length) leaves the list unchanged and reports the error code.
module cursor_array_list_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic                        clear_request,
    input  logic [cal_pkg::ELEM_W-1:0]  item_value,
    input  logic [cal_pkg::CNT_W-1:0]   target_position,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cal_pkg::ELEM_W-1:0]  removed_value,
    output logic [cal_pkg::CNT_W-1:0]   list_length,
    output logic [cal_pkg::CNT_W-1:0]   cursor_position,
    output logic [1:0]                  error_code
);

    logic                        in_accept;
    cal_pkg::op_t                op;
    cal_pkg::cell_cmd_t          cmd;

    // List control state.
    logic [cal_pkg::CNT_W-1:0]   count_reg;
    logic [cal_pkg::CNT_W-1:0]   count_next;
    logic [cal_pkg::CNT_W-1:0]   cursor_reg;
    logic [cal_pkg::CNT_W-1:0]   cursor_next;

    // Output word register.
    logic                        out_valid_reg;
    logic [cal_pkg::ELEM_W-1:0]  removed_reg;
    logic [cal_pkg::ELEM_W-1:0]  removed_next;
    cal_pkg::err_t               err_reg;
    cal_pkg::err_t               err_next;

    // Chain wiring.
    logic [cal_pkg::ELEM_W-1:0]  cell_data [cal_pkg::CAPACITY];
    logic [cal_pkg::ELEM_W-1:0]  cell_sel  [cal_pkg::CAPACITY];
    logic [cal_pkg::ELEM_W-1:0]  cursor_elem;

    logic                        is_full;
    logic                        has_elem;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign op        = cal_pkg::op_t'(operation);

    assign is_full  = (count_reg == cal_pkg::CNT_W'(cal_pkg::CAPACITY));
    assign has_elem = (cursor_reg < count_reg);

    // The element under the cursor: at most one cell drives a non-zero value.
    always_comb
    begin
        cursor_elem = '0;
        for (int i = 0; i < cal_pkg::CAPACITY; i++)
        begin
            cursor_elem = cursor_elem | cell_sel[i];
        end
    end

    // Decode one operation into the new count, cursor and cell command.
    always_comb
    begin
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        removed_next = '0;
        err_next     = cal_pkg::ERR_OK;
        cmd.ins      = 1'b0;
        cmd.app      = 1'b0;
        cmd.rem      = 1'b0;
        cmd.cursor   = cursor_reg;
        cmd.count    = count_reg;
        cmd.item     = item_value;
        if (clear_request)
        begin
            count_next  = '0;
            cursor_next = '0;
        end
        else
        begin
            case (op)
                cal_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        err_next = cal_pkg::ERR_FULL;
                    end
                    else
                    begin
                        cmd.ins    = in_accept;
                        count_next = count_reg + cal_pkg::CNT_W'(1);
                    end
                end
                cal_pkg::OP_APPEND:
                begin
                    if (is_full)
                    begin
                        err_next = cal_pkg::ERR_FULL;
                    end
                    else
                    begin
                        cmd.app    = in_accept;
                        count_next = count_reg + cal_pkg::CNT_W'(1);
                    end
                end
                cal_pkg::OP_REMOVE:
                begin
                    if (!has_elem)
                    begin
                        err_next = cal_pkg::ERR_NO_ELEM;
                    end
                    else
                    begin
                        cmd.rem      = in_accept;
                        removed_next = cursor_elem;
                        count_next   = count_reg - cal_pkg::CNT_W'(1);
                    end
                end
                cal_pkg::OP_TO_START:
                begin
                    cursor_next = '0;
                end
                cal_pkg::OP_TO_END:
                begin
                    cursor_next = count_reg;
                end
                cal_pkg::OP_PREV:
                begin
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - cal_pkg::CNT_W'(1);
                    end
                end
                cal_pkg::OP_NEXT:
                begin
                    if (has_elem)
                    begin
                        cursor_next = cursor_reg + cal_pkg::CNT_W'(1);
                    end
                end
                cal_pkg::OP_SET_POS:
                begin
                    if (target_position > count_reg)
                    begin
                        err_next = cal_pkg::ERR_BAD_POS;
                    end
                    else
                    begin
                        cursor_next = target_position;
                    end
                end
                default:
                begin
                    err_next = cal_pkg::ERR_OK;
                end
            endcase
        end
    end

    // The chain of element cells; the ends see zero from outside the chain.
    for (genvar g = 0; g < cal_pkg::CAPACITY; g++)
    begin : g_cell
        logic [cal_pkg::ELEM_W-1:0] left_w;
        logic [cal_pkg::ELEM_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = cell_data[g-1];
        end

        if (g == cal_pkg::CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = cell_data[g+1];
        end

        cal_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .index      (cal_pkg::CNT_W'(g)),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g]),
            .sel_data   (cell_sel[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg     <= count_next;
                cursor_reg    <= cursor_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            removed_reg <= removed_next;
            err_reg     <= err_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign removed_value   = removed_reg;
    assign list_length     = count_reg;
    assign cursor_position = cursor_reg;
    assign error_code      = err_reg;

    // The length never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cal_pkg::CNT_W'(cal_pkg::CAPACITY))
        else $error("list length beyond capacity");

    // The cursor always points at or before the end of the list.
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond list length");

    // A clear leaves an empty list with the cursor at zero and no error.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && clear_request |=>
        count_reg == '0 && cursor_reg == '0 && err_reg == cal_pkg::ERR_OK)
        else $error("clear did not empty the list");

    // A full error is only reported against a full list.
    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg == cal_pkg::ERR_FULL |->
        count_reg == cal_pkg::CNT_W'(cal_pkg::CAPACITY))
        else $error("full error with room left");

endmodule

// ===== hw/rtl/cal_cell.sv =====
module cal_cell (
    input  logic                        clk,
    input  cal_pkg::cell_cmd_t          cmd,
    input  logic [cal_pkg::CNT_W-1:0]   index,
    input  logic [cal_pkg::ELEM_W-1:0]  left_data,
    input  logic [cal_pkg::ELEM_W-1:0]  right_data,
    output logic [cal_pkg::ELEM_W-1:0]  data,
    output logic [cal_pkg::ELEM_W-1:0]  sel_data
);

    logic [cal_pkg::ELEM_W-1:0] data_reg;
    logic [cal_pkg::ELEM_W-1:0] data_next;
    logic [cal_pkg::CNT_W-1:0]  index_p1;

    assign index_p1 = index + cal_pkg::CNT_W'(1);

    // Each cell either keeps its element, takes the new item, or takes the
    // element of a neighbour when the list opens or closes a gap.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins && index == cmd.cursor)
        begin
            data_next = cmd.item;
        end
        else if (cmd.ins && index > cmd.cursor && index <= cmd.count)
        begin
            data_next = left_data;
        end
        else if (cmd.app && index == cmd.count)
        begin
            data_next = cmd.item;
        end
        else if (cmd.rem && index >= cmd.cursor && index_p1 < cmd.count)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (index == cmd.cursor) ? data_reg : '0;

endmodule
